// File: rtl/krm_pkg.sv
// ----------------------------------------------------------------------------
// krm_pkg: shared types and constants for the keyboard report merger
// Holds the event codes, the held-key entry layout and the control and
// status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package krm_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_KEYS_DEF     = 16;
  localparam int REPORT_SLOTS_DEF = 6;

  // Fixed report layout
  localparam int CODE_FIELDS = 6;
  localparam int SLOT_W      = 3;   // indexes CODE_FIELDS slots, holds up to CODE_FIELDS
  localparam logic [7:0] ROLLOVER_CODE = 8'h01;

  // Event codes on the mode field
  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_ALL     = 2'd2
  } mode_t;

  // One held key: modifier mask and its keycodes
  typedef struct packed {
    logic [7:0]                  modifier;
    logic [CODE_FIELDS-1:0][7:0] codes;
  } entry_t;

  // Commands from the controller
  typedef struct packed {
    logic              latch;   // capture the request
    logic              apply;   // update the key table, clear the merge
    logic              rd;      // read the entry of the selected key
    logic              load;    // OR in the modifier of the entry just read
    logic              step;    // walk one keycode slot
    logic [SLOT_W-1:0] slot;
    logic              finish;  // compare and publish the report
  } cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic ev_valid;    // latched request changes the table
    logic key_active;  // selected key is held
    logic over;        // rollover already seen
    logic step_over;   // current slot step hits rollover
  } status_t;

endpackage

// File: rtl/krm_ctrl.sv
// ----------------------------------------------------------------------------
// krm_ctrl: sequencer for the keyboard report merger
// Accepts a request and, if it changes the table, has it applied, then walks
// the keys and the slots of each held key, stopping early on a rollover,
// before asking the datapath to publish the report.
module krm_ctrl #(
  parameter int NUM_KEYS     = 16,
  parameter int REPORT_SLOTS = 6,
  parameter int KW           = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  krm_pkg::status_t  status,
  output krm_pkg::cmd_t     cmd,
  output logic [KW-1:0]     key
);
  import krm_pkg::*;

  localparam int CW = $clog2(NUM_KEYS + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_LOAD   = 6'b001000,
    ST_SLOT   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     key_cnt, key_cnt_next;
  logic [SLOT_W-1:0] slot_cnt, slot_cnt_next;

  assign busy = (state != ST_IDLE);
  assign key  = key_cnt[KW-1:0];

  // Next state and commands
  always_comb begin
    state_next    = state;
    key_cnt_next  = key_cnt;
    slot_cnt_next = slot_cnt;
    cmd           = '0;
    cmd.slot      = slot_cnt;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.ev_valid) begin
          cmd.apply    = 1'b1;
          key_cnt_next = '0;
          state_next   = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status.over || key_cnt == CW'(NUM_KEYS)) begin
          state_next = ST_FINISH;
        end else if (status.key_active) begin
          cmd.rd     = 1'b1;
          state_next = ST_LOAD;
        end else begin
          key_cnt_next = key_cnt + 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.load      = 1'b1;
        slot_cnt_next = '0;
        state_next    = ST_SLOT;
      end
      ST_SLOT: begin
        cmd.step = 1'b1;
        if (status.step_over || slot_cnt == SLOT_W'(REPORT_SLOTS - 1)) begin
          key_cnt_next = key_cnt + 1'b1;
          state_next   = ST_SCAN;
        end else begin
          slot_cnt_next = slot_cnt + 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      key_cnt  <= '0;
      slot_cnt <= '0;
    end else begin
      state    <= state_next;
      key_cnt  <= key_cnt_next;
      slot_cnt <= slot_cnt_next;
    end
  end

endmodule

// File: rtl/krm_dpath.sv
// ----------------------------------------------------------------------------
// krm_dpath: key table and merge datapath
// Holds the held-key memory and active flags, the packing registers of the
// merge in progress and the last published report.
// ----------------------------------------------------------------------------
module krm_dpath #(
  parameter int NUM_KEYS     = 16,
  parameter int REPORT_SLOTS = 6,
  parameter int KW           = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  krm_pkg::cmd_t    cmd,
  input  logic [KW-1:0]    key,
  output krm_pkg::status_t status,
  input  logic [1:0]       mode,
  input  logic [4:0]       key_index,
  input  logic [7:0]       press_modifier,
  input  logic [7:0]       press_code_0,
  input  logic [7:0]       press_code_1,
  input  logic [7:0]       press_code_2,
  input  logic [7:0]       press_code_3,
  input  logic [7:0]       press_code_4,
  input  logic [7:0]       press_code_5,
  output logic             report_valid,
  output logic [7:0]       report_modifier,
  output logic [7:0]       report_code_0,
  output logic [7:0]       report_code_1,
  output logic [7:0]       report_code_2,
  output logic [7:0]       report_code_3,
  output logic [7:0]       report_code_4,
  output logic [7:0]       report_code_5
);
  import krm_pkg::*;

  // Latched request
  logic [1:0] mode_r;
  logic [4:0] idx_r;
  entry_t     entry_r;
  logic       idx_ok;
  logic [KW-1:0] idx_w;
  logic       ev_valid;

  // Key table
  entry_t              mem [NUM_KEYS];
  entry_t              rd_entry;
  logic [NUM_KEYS-1:0] active;

  // Merge in progress
  logic [7:0]                  mrg_mod;
  logic [CODE_FIELDS-1:0][7:0] packed_codes;
  logic [SLOT_W-1:0]           count;
  logic                        over;
  logic [7:0]                  step_code;
  logic                        dup;
  logic                        step_new;
  logic [CODE_FIELDS-1:0][7:0] final_codes;

  // Published report
  logic [7:0]                  cur_mod;
  logic [CODE_FIELDS-1:0][7:0] cur_codes;

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r                 <= mode;
      idx_r                  <= key_index;
      entry_r.modifier       <= press_modifier;
      entry_r.codes[0]       <= press_code_0;
      entry_r.codes[1]       <= press_code_1;
      entry_r.codes[2]       <= press_code_2;
      entry_r.codes[3]       <= press_code_3;
      entry_r.codes[4]       <= press_code_4;
      entry_r.codes[5]       <= press_code_5;
    end
  end

  assign idx_ok = ({1'b0, idx_r} < 6'(NUM_KEYS));
  assign idx_w  = idx_r[KW-1:0];

  // Does the request change the table
  always_comb begin
    unique case (mode_r)
      MODE_PRESS:   ev_valid = idx_ok;
      MODE_RELEASE: ev_valid = idx_ok && active[idx_w];
      MODE_ALL:     ev_valid = 1'b1;
      default:      ev_valid = 1'b0;
    endcase
  end

  assign status.ev_valid   = ev_valid;
  assign status.key_active = active[key];
  assign status.over       = over;

  // Entry memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.apply && mode_r == MODE_PRESS) begin
      mem[idx_w] <= entry_r;
    end
    if (cmd.rd) begin
      rd_entry <= mem[key];
    end
  end

  // Active flags
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.apply) begin
      unique case (mode_r)
        MODE_PRESS:   active[idx_w] <= 1'b1;
        MODE_RELEASE: active[idx_w] <= 1'b0;
        MODE_ALL:     active        <= '0;
        default:      active        <= active;
      endcase
    end
  end

  // Slot step: skip empty and already packed codes
  assign step_code = rd_entry.codes[cmd.slot];

  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < CODE_FIELDS; i++) begin
      if (SLOT_W'(i) < count && packed_codes[i] == step_code) begin
        dup = 1'b1;
      end
    end
  end

  assign step_new         = cmd.step && (step_code != 8'h00) && !dup;
  assign status.step_over = step_new && (count >= SLOT_W'(REPORT_SLOTS));

  // Packing registers
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      mrg_mod      <= '0;
      packed_codes <= '0;
      count        <= '0;
      over         <= 1'b0;
    end else if (cmd.load) begin
      mrg_mod <= mrg_mod | rd_entry.modifier;
    end else if (status.step_over) begin
      over <= 1'b1;
    end else if (step_new) begin
      packed_codes[count] <= step_code;
      count               <= count + 1'b1;
    end
  end

  // Rollover fills the used slots
  always_comb begin
    for (int i = 0; i < CODE_FIELDS; i++) begin
      if (over) begin
        final_codes[i] = (i < REPORT_SLOTS) ? ROLLOVER_CODE : 8'h00;
      end else begin
        final_codes[i] = packed_codes[i];
      end
    end
  end

  // Publish only a changed report
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mod      <= '0;
      cur_codes    <= '0;
      report_valid <= 1'b0;
    end else begin
      report_valid <= 1'b0;
      if (cmd.finish && (mrg_mod != cur_mod || final_codes != cur_codes)) begin
        cur_mod      <= mrg_mod;
        cur_codes    <= final_codes;
        report_valid <= 1'b1;
      end
    end
  end

  assign report_modifier = cur_mod;
  assign report_code_0   = cur_codes[0];
  assign report_code_1   = cur_codes[1];
  assign report_code_2   = cur_codes[2];
  assign report_code_3   = cur_codes[3];
  assign report_code_4   = cur_codes[4];
  assign report_code_5   = cur_codes[5];

endmodule

// File: rtl/keyboard_report_merger.sv
// ----------------------------------------------------------------------------
// keyboard_report_merger: six-slot boot keyboard report builder
// Keeps a table of held keys and merges them into one report per change.
// ----------------------------------------------------------------------------
// A request (press, release one, release all) is taken when start is high
// and busy is low. The block then walks the table: each key index, plus
// a load step and the slot steps of each held key, then a finish step; a
// rollover ends the walk early. The walk is set by the single read port of
// the entry memory and the one-slot packing step. Ignored requests hold
// busy high for one cycle, no result.
// A changed report is shown on the report ports with report_valid high for
// exactly one cycle; the receiver cannot stall it, and the report ports
// keep the last report afterwards.
module keyboard_report_merger #(
  parameter int NUM_KEYS     = krm_pkg::NUM_KEYS_DEF,
  parameter int REPORT_SLOTS = krm_pkg::REPORT_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode,
  input  logic [4:0] key_index,
  input  logic [7:0] press_modifier,
  input  logic [7:0] press_code_0,
  input  logic [7:0] press_code_1,
  input  logic [7:0] press_code_2,
  input  logic [7:0] press_code_3,
  input  logic [7:0] press_code_4,
  input  logic [7:0] press_code_5,
  output logic       report_valid,
  output logic [7:0] report_modifier,
  output logic [7:0] report_code_0,
  output logic [7:0] report_code_1,
  output logic [7:0] report_code_2,
  output logic [7:0] report_code_3,
  output logic [7:0] report_code_4,
  output logic [7:0] report_code_5
);
  import krm_pkg::*;

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  cmd_t          cmd;
  status_t       status;
  logic [KW-1:0] key;

  // Sequencer
  krm_ctrl #(
    .NUM_KEYS     (NUM_KEYS),
    .REPORT_SLOTS (REPORT_SLOTS),
    .KW           (KW)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd),
    .key    (key)
  );

  // Table and merge datapath
  krm_dpath #(
    .NUM_KEYS     (NUM_KEYS),
    .REPORT_SLOTS (REPORT_SLOTS),
    .KW           (KW)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .key             (key),
    .status          (status),
    .mode            (mode),
    .key_index       (key_index),
    .press_modifier  (press_modifier),
    .press_code_0    (press_code_0),
    .press_code_1    (press_code_1),
    .press_code_2    (press_code_2),
    .press_code_3    (press_code_3),
    .press_code_4    (press_code_4),
    .press_code_5    (press_code_5),
    .report_valid    (report_valid),
    .report_modifier (report_modifier),
    .report_code_0   (report_code_0),
    .report_code_1   (report_code_1),
    .report_code_2   (report_code_2),
    .report_code_3   (report_code_3),
    .report_code_4   (report_code_4),
    .report_code_5   (report_code_5)
  );

endmodule

// File: test/keyboard_report_merger_tb.sv
// ----------------------------------------------------------------------------
// keyboard_report_merger_tb: self-checking bench for the report merger
// Sends press, release and release-all requests with random spacing, keeps
// its own copy of the held-key table, works out each changed report when a
// request is taken and checks the reports that come back, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keyboard_report_merger_tb;
  import krm_pkg::*;

  localparam int KEYS  = NUM_KEYS_DEF;
  localparam int SLOTS = REPORT_SLOTS_DEF;
  localparam int RANDOM_REQUESTS = 600;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // One request as the driver presents it, with the idle gap that follows it
  typedef struct {
    logic [1:0]  mode;
    logic [4:0]  key;
    entry_t      press;
    int unsigned gap;
    bit          drain;  // hold off until every report due has come back
  } key_request_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] mode = '0;
  logic [4:0] key_index = '0;
  logic [7:0] press_modifier = '0;
  logic [7:0] press_code_0 = '0;
  logic [7:0] press_code_1 = '0;
  logic [7:0] press_code_2 = '0;
  logic [7:0] press_code_3 = '0;
  logic [7:0] press_code_4 = '0;
  logic [7:0] press_code_5 = '0;
  logic       report_valid;
  logic [7:0] report_modifier;
  logic [7:0] report_code_0;
  logic [7:0] report_code_1;
  logic [7:0] report_code_2;
  logic [7:0] report_code_3;
  logic [7:0] report_code_4;
  logic [7:0] report_code_5;

  key_request_t key_requests[$];
  entry_t       expected_reports[$];

  // Predictor copy of the held-key table and of the last report sent
  entry_t held_entry [KEYS] = '{default: '0};
  bit     held_on    [KEYS] = '{default: 1'b0};
  entry_t last_report = '0;

  int unsigned idle_cnt = 0;
  logic        taken = 1'b0;
  int          mismatches = 0;

  keyboard_report_merger u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Walk held keys in index order: OR modifiers, pack distinct codes,
  // stop on the first code that finds every slot full
  function automatic entry_t merge_held_keys();
    entry_t     m;
    int         n;
    bit         over;
    bit         dup;
    logic [7:0] c;
    m = '0;
    n = 0;
    over = 1'b0;
    for (int k = 0; k < KEYS && !over; k++) begin
      if (held_on[k]) begin
        m.modifier |= held_entry[k].modifier;
        for (int s = 0; s < SLOTS && !over; s++) begin
          c = held_entry[k].codes[s];
          dup = 1'b0;
          for (int i = 0; i < n; i++)
            if (m.codes[i] == c) dup = 1'b1;
          if (c != 8'h00 && !dup) begin
            if (n >= SLOTS) begin
              over = 1'b1;
            end else begin
              m.codes[n] = c;
              n++;
            end
          end
        end
      end
    end
    if (over)
      for (int s = 0; s < SLOTS; s++) m.codes[s] = ROLLOVER_CODE;
    return m;
  endfunction

  // Update the table for a taken request; queue the report if it changed
  function automatic void apply_key_request(logic [1:0] m, logic [4:0] k, entry_t e);
    entry_t merged;
    bit     touched;
    touched = 1'b0;
    case (m)
      MODE_PRESS: begin
        if (k < KEYS) begin
          held_entry[k] = e;
          held_on[k] = 1'b1;
          touched = 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (k < KEYS && held_on[k]) begin
          held_on[k] = 1'b0;
          touched = 1'b1;
        end
      end
      MODE_ALL: begin
        held_on = '{default: 1'b0};
        touched = 1'b1;
      end
      default: ;
    endcase
    if (touched) begin
      merged = merge_held_keys();
      if (merged != last_report) begin
        last_report = merged;
        expected_reports.push_back(merged);
      end
    end
  endfunction

  // Codes are given as {slot 5, ..., slot 0}
  function automatic void queue_request(logic [1:0] m, logic [4:0] k, logic [7:0] md,
                                        logic [5:0][7:0] codes, bit drain);
    key_request_t r;
    r.mode = m;
    r.key = k;
    r.press.modifier = md;
    r.press.codes = codes;
    r.gap = $urandom_range(0, 15);
    r.drain = drain;
    key_requests.push_back(r);
  endfunction

  // Driver: present the next request at the falling edge, hold it until taken
  always @(negedge clk) begin : drive_requests
    key_request_t nxt;
    logic         go;
    go = 1'b0;
    if (rst) begin
      go = 1'b0;
    end else if (start && !taken) begin
      go = 1'b1;
    end else if (idle_cnt != 0) begin
      idle_cnt <= idle_cnt - 1;
    end else if (key_requests.size() != 0 &&
                 (!key_requests[0].drain || expected_reports.size() == 0)) begin
      nxt = key_requests.pop_front();
      mode <= nxt.mode;
      key_index <= nxt.key;
      press_modifier <= nxt.press.modifier;
      press_code_0 <= nxt.press.codes[0];
      press_code_1 <= nxt.press.codes[1];
      press_code_2 <= nxt.press.codes[2];
      press_code_3 <= nxt.press.codes[3];
      press_code_4 <= nxt.press.codes[4];
      press_code_5 <= nxt.press.codes[5];
      idle_cnt <= nxt.gap;
      go = 1'b1;
    end
    start <= go;
  end

  // Monitor: check a report first, then predict for a request taken this edge
  always @(posedge clk) begin : check_reports
    entry_t seen;
    entry_t want;
    entry_t pressed;
    taken <= !rst && start && !busy;
    if (!rst) begin
      if (report_valid) begin
        seen.modifier = report_modifier;
        seen.codes = {report_code_5, report_code_4, report_code_3,
                      report_code_2, report_code_1, report_code_0};
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t: report with none due: expected nothing, actual mod %h codes %h",
                   $time, seen.modifier, seen.codes);
        end else begin
          want = expected_reports.pop_front();
          if (want.modifier !== seen.modifier) begin
            mismatches++;
            $display("%0t: report_modifier expected %h actual %h",
                     $time, want.modifier, seen.modifier);
          end
          for (int s = 0; s < CODE_FIELDS; s++) begin
            if (want.codes[s] !== seen.codes[s]) begin
              mismatches++;
              $display("%0t: report_code_%0d expected %h actual %h",
                       $time, s, want.codes[s], seen.codes[s]);
            end
          end
        end
      end
      if (start && !busy) begin
        pressed.modifier = press_modifier;
        pressed.codes = {press_code_5, press_code_4, press_code_3,
                         press_code_2, press_code_1, press_code_0};
        apply_key_request(mode, key_index, pressed);
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    key_request_t r;
    int unsigned  pick;
    int unsigned  ncodes;
    int unsigned  sel;
    logic [7:0]   code;

    // Directed part
    queue_request(MODE_PRESS, 5'd0, 8'h11, {8'h00, 8'h00, 8'h00, 8'h06, 8'h05, 8'h04}, 0);
    // same assignment again: report unchanged
    queue_request(MODE_PRESS, 5'd0, 8'h11, {8'h00, 8'h00, 8'h00, 8'h06, 8'h05, 8'h04}, 0);
    // repeated code is packed once
    queue_request(MODE_PRESS, 5'd1, 8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h07, 8'h05}, 0);
    // seventh distinct code: rollover
    queue_request(MODE_PRESS, 5'd2, 8'h02, {8'h00, 8'h00, 8'h0B, 8'h0A, 8'h09, 8'h08}, 0);
    // key after the rollover: its modifier is left out, no change
    queue_request(MODE_PRESS, 5'd3, 8'h80, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0C}, 0);
    queue_request(MODE_RELEASE, 5'd2, 8'h00, '0, 0);
    // last key, code in the top slot
    queue_request(MODE_PRESS, 5'd15, 8'h40, {8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF}, 0);
    // out-of-range presses are ignored
    queue_request(MODE_PRESS, 5'd16, 8'hFF, {6{8'hFF}}, 0);
    queue_request(MODE_PRESS, 5'd31, 8'hFF, {6{8'hFF}}, 0);
    // release of an idle key and out of range
    queue_request(MODE_RELEASE, 5'd9, 8'h00, '0, 0);
    queue_request(MODE_RELEASE, 5'd31, 8'hFF, {6{8'hFF}}, 0);
    queue_request(MODE_UNUSED, 5'd0, 8'hFF, {6{8'hFF}}, 0);
    queue_request(MODE_RELEASE, 5'd15, 8'h00, '0, 0);
    // one key with the same code in every slot
    queue_request(MODE_PRESS, 5'd4, 8'h00, {6{8'hFF}}, 0);
    // rollover code used as a keycode
    queue_request(MODE_PRESS, 5'd5, 8'h08, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ROLLOVER_CODE}, 0);
    queue_request(MODE_ALL, 5'd0, 8'h00, '0, 1);
    queue_request(MODE_ALL, 5'd31, 8'h00, '0, 0);
    // empty assignment leaves the report empty
    queue_request(MODE_PRESS, 5'd0, 8'h00, '0, 0);
    queue_request(MODE_PRESS, 5'd7, 8'h01, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80}, 0);
    queue_request(MODE_RELEASE, 5'd0, 8'h00, '0, 0);
    queue_request(MODE_ALL, 5'd0, 8'h00, '0, 0);

    // Random part: mostly presses from a small code pool, so duplicates and
    // rollover are common, with releases and release-all to empty the table
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pick = $urandom_range(0, 99);
      r.press.modifier = $urandom_range(0, 1) ? (8'h01 << $urandom_range(0, 7))
                                              : 8'($urandom);
      ncodes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : $urandom_range(0, 3);
      r.press.codes = '0;
      for (int j = 0; j < ncodes; j++) begin
        sel = $urandom_range(0, 19);
        if (sel < 2)
          code = ROLLOVER_CODE;
        else if (sel < 16)
          code = 8'($urandom_range(4, 15));
        else
          code = 8'($urandom);
        r.press.codes[$urandom_range(0, CODE_FIELDS - 1)] = code;
      end
      if (pick < 60) begin
        r.mode = MODE_PRESS;
        r.key = 5'($urandom_range(0, KEYS - 1));
      end else if (pick < 62) begin
        r.mode = MODE_PRESS;
        r.key = 5'($urandom_range(KEYS, 31));
      end else if (pick < 85) begin
        r.mode = MODE_RELEASE;
        r.key = 5'($urandom_range(0, KEYS - 1));
      end else if (pick < 88) begin
        r.mode = MODE_RELEASE;
        r.key = 5'($urandom_range(KEYS, 31));
      end else if (pick < 95) begin
        r.mode = MODE_ALL;
        r.key = 5'($urandom);
      end else begin
        r.mode = MODE_UNUSED;
        r.key = 5'($urandom);
      end
      // every fourth stretch of 40 requests runs back to back
      r.gap = ((i / 40) % 4 == 1) ? 0 : $urandom_range(0, 15);
      r.drain = (i % 75 == 74);
      key_requests.push_back(r);
    end

    while (key_requests.size() != 0 || start) @(posedge clk);
    while (expected_reports.size() != 0 || busy) @(posedge clk);
    // room for a stray late report
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("keyboard_report_merger: match");
    else
      $display("keyboard_report_merger: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("keyboard_report_merger: mismatch");
    $finish;
  end

endmodule
